[sv/dlu_pkg.sv]
`default_nettype none
package dlu_pkg;

    localparam int DEF_MAX_ORDER = 8;
    localparam int ORDER_LIMIT   = 8;
    localparam int CFG_W         = 4;
    localparam int VAL_W         = 32;
    localparam int FRAC_W        = 16;
    localparam int PROD_W        = 48;
    localparam int ACC_W         = 52;
    localparam int QUO_W         = VAL_W + FRAC_W;
    localparam logic [CFG_W-1:0] SIZE_RESET = 4'd1;

    typedef enum logic [1:0] {
        OP_WR_MAT = 2'd0,
        OP_FACT   = 2'd1,
        OP_WR_RHS = 2'd2,
        OP_SOLVE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_ZERO = 2'd1,
        STAT_SAT  = 2'd2
    } t_status;

    // source of a cell's second read port, and target of a cell write
    typedef enum logic [1:0] {
        SRC_MAT = 2'd0,
        SRC_X   = 2'd1,
        SRC_B   = 2'd2
    } t_src;

    typedef enum logic [1:0] {
        MODE_FACT = 2'd0,
        MODE_FWD  = 2'd1,
        MODE_BWD  = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BASE_RD,
        ST_BASE_LAT,
        ST_TERM_RD,
        ST_TERM_LAT,
        ST_MUL,
        ST_ACC,
        ST_DIFF,
        ST_DEN_RD,
        ST_DEN_LAT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_WRITE,
        ST_CHK_RD,
        ST_CHK_TST,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic rd_a;
        logic rd_b;
        t_src b_src;
        logic wr;
        t_src wr_sel;
    } t_cell_ctl;

endpackage
`default_nettype wire

[sv/dlu_cell.sv]
`default_nettype none
module dlu_cell #(
    parameter int MAX_ORDER = 8,
    parameter int CELL_ID   = 0
) (
    input  wire                          i_clk,
    input  wire dlu_pkg::t_cell_ctl      i_ctl,
    input  wire [$clog2(MAX_ORDER)-1:0]  i_a_row,
    input  wire [$clog2(MAX_ORDER)-1:0]  i_a_col,
    input  wire [$clog2(MAX_ORDER)-1:0]  i_b_row,
    input  wire [$clog2(MAX_ORDER)-1:0]  i_b_col,
    input  wire [$clog2(MAX_ORDER)-1:0]  i_wr_row,
    input  wire [$clog2(MAX_ORDER)-1:0]  i_wr_col,
    input  wire [dlu_pkg::VAL_W-1:0]     i_wr_data,
    input  wire [dlu_pkg::VAL_W-1:0]     i_a_chain,
    input  wire [dlu_pkg::VAL_W-1:0]     i_b_chain,
    output logic [dlu_pkg::VAL_W-1:0]    o_a_chain,
    output logic [dlu_pkg::VAL_W-1:0]    o_b_chain
);
    import dlu_pkg::*;

    localparam int RW = $clog2(MAX_ORDER);
    localparam logic [RW-1:0] MY_ROW = RW'(CELL_ID);

    logic [VAL_W-1:0] r_row [MAX_ORDER];
    logic [VAL_W-1:0] r_b;
    logic [VAL_W-1:0] r_x;
    logic [VAL_W-1:0] r_qa;
    logic [VAL_W-1:0] r_qb;
    logic             hit_a;
    logic             hit_b;
    logic [RW-1:0]    rd_col;

    // one row read per cycle: only one port ever targets this row at a time
    assign hit_a  = i_ctl.rd_a && (i_a_row == MY_ROW);
    assign hit_b  = i_ctl.rd_b && (i_b_row == MY_ROW);
    assign rd_col = hit_a ? i_a_col : i_b_col;

    // store row entries, rhs entry and solution entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && (i_wr_row == MY_ROW)) begin
            case (i_ctl.wr_sel)
                SRC_MAT: r_row[i_wr_col] <= i_wr_data;
                SRC_B:   r_b <= i_wr_data;
                SRC_X:   r_x <= i_wr_data;
                default: r_b <= r_b;
            endcase
        end
    end

    // register reads, zero when this row is not addressed
    always_ff @(posedge i_clk) begin
        r_qa <= hit_a ? r_row[rd_col] : '0;
        if (!hit_b) begin
            r_qb <= '0;
        end else begin
            case (i_ctl.b_src)
                SRC_X:   r_qb <= r_x;
                SRC_B:   r_qb <= r_b;
                default: r_qb <= r_row[rd_col];
            endcase
        end
    end

    // merge into the read chain toward the next cell
    assign o_a_chain = i_a_chain | r_qa;
    assign o_b_chain = i_b_chain | r_qb;

endmodule
`default_nettype wire

[sv/dlu_div.sv]
`default_nettype none
module dlu_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [dlu_pkg::VAL_W-1:0]     i_num,
    input  wire [dlu_pkg::VAL_W-1:0]     i_den,
    output logic                         o_done,
    output logic [dlu_pkg::VAL_W-1:0]    o_quot,
    output logic                         o_ovf
);
    import dlu_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic               r_run;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [VAL_W:0]     r_rem;
    logic [QUO_W-1:0]   r_q;
    logic [VAL_W-1:0]   r_dmag;
    logic               r_neg;
    logic [VAL_W:0]     trial;
    logic               ge;
    logic [VAL_W-1:0]   num_mag;
    logic [VAL_W-1:0]   den_mag;

    assign num_mag = i_num[VAL_W-1] ? (~i_num + 1'b1) : i_num;
    assign den_mag = i_den[VAL_W-1] ? (~i_den + 1'b1) : i_den;
    assign trial   = {r_rem[VAL_W-1:0], r_q[QUO_W-1]};
    assign ge      = trial >= {1'b0, r_dmag};

    // run control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(QUO_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= {num_mag, {FRAC_W{1'b0}}};
            r_rem  <= '0;
            r_dmag <= den_mag;
            r_neg  <= i_num[VAL_W-1] ^ i_den[VAL_W-1];
        end else if (r_run) begin
            r_rem <= ge ? (trial - {1'b0, r_dmag}) : trial;
            r_q   <= {r_q[QUO_W-2:0], ge};
        end
    end

    // apply sign and saturate
    always_comb begin
        o_ovf  = 1'b0;
        o_quot = r_q[VAL_W-1:0];
        if (r_neg) begin
            if (r_q > QUO_W'(64'h8000_0000)) begin
                o_ovf  = 1'b1;
                o_quot = 32'h8000_0000;
            end else begin
                o_quot = ~r_q[VAL_W-1:0] + 1'b1;
            end
        end else if (r_q > QUO_W'(64'h7FFF_FFFF)) begin
            o_ovf  = 1'b1;
            o_quot = 32'h7FFF_FFFF;
        end
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

[sv/dense_lu_factor_solve_top.sv]
`default_nettype none
// Dense LU factorization and triangular solve, signed Q16.16.
// Command channel: i_start with i_operation, i_row, i_col, i_value; a
// transaction is taken on a clock edge with i_start high and o_busy low.
// Matrix and rhs writes leave o_busy low. Factorize and solve raise o_busy
// until their last result has been driven.
// Results: o_strobe marks each result for one cycle; the receiver cannot
// stall and must take every strobed transaction.
// Config: i_cfg_valid/o_cfg_ready write the system order (always ready).
// Storage sits in a chain of row cells; each cell holds one matrix row, its
// rhs entry and its solution entry, and ORs its registered read data into
// the chain passed on to the next cell.
// Datapath: one shared multiply-accumulate path handles each product term
// (operand read, multiply, accumulate); each entry adds a base read, a
// difference and a write back, and each division adds a divisor read and a
// run of the bit-serial divider. The last result is strobed in the first
// cycle after o_busy falls; solution entries leave one per cycle. Reset
// clears control state and sets the order to 1; stored entries are
// undefined until written.
module dense_lu_factor_solve_top #(
    parameter int MAX_ORDER = dlu_pkg::DEF_MAX_ORDER
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    output logic                         o_busy,
    input  wire [1:0]                    i_operation,
    input  wire [2:0]                    i_row,
    input  wire [2:0]                    i_col,
    input  wire [dlu_pkg::VAL_W-1:0]     i_value,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [dlu_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                         o_strobe,
    output logic [2:0]                   o_index,
    output logic [dlu_pkg::VAL_W-1:0]    o_result_value,
    output logic                         o_last,
    output logic [1:0]                   o_status
);
    import dlu_pkg::*;

    localparam int RW  = $clog2(MAX_ORDER);
    localparam int CW  = RW + 1;
    localparam int CAP = (MAX_ORDER < ORDER_LIMIT) ? MAX_ORDER : ORDER_LIMIT;

    t_state             r_state, n_state;
    t_mode              r_mode;
    logic [CFG_W-1:0]   r_size;
    logic [CW-1:0]      r_k, r_i, r_j, r_end;
    logic               r_sub;
    logic               r_zero, r_sat;
    logic [VAL_W-1:0]   r_base, r_opa, r_opb, r_val, r_den;
    logic [PROD_W-1:0]  r_prod;
    logic [ACC_W-1:0]   r_acc;
    logic               r_emv, r_eml;
    logic [CW-1:0]      r_emi;
    logic               r_strobe, r_last;
    logic [2:0]         r_index;
    logic [VAL_W-1:0]   r_res;
    t_status            r_status;

    logic [CW-1:0]      n_ord;
    logic               acc_go;
    t_op                op;
    logic [CW-1:0]      t_tr, t_tc, t_js, t_end;
    logic               t_div;
    logic               last_fact, is_fact;
    t_cell_ctl          cell_ctl;
    logic [RW-1:0]      a_row, a_col, b_row, b_col, wr_row, wr_col;
    logic [VAL_W-1:0]   wr_data;
    logic [VAL_W-1:0]   a_ch [MAX_ORDER+1];
    logic [VAL_W-1:0]   b_ch [MAX_ORDER+1];
    logic [VAL_W-1:0]   rd_a, rd_b;
    logic signed [63:0] prod_full, prod_rnd;
    logic signed [ACC_W:0] diff;
    logic [VAL_W-1:0]   diff_sat;
    logic               diff_ovf;
    logic               div_go, div_done, div_ovf;
    logic [VAL_W-1:0]   div_quot;
    t_status            stat_now;

    assign op     = t_op'(i_operation);
    assign acc_go = i_start && !o_busy;
    assign o_busy = (r_state != ST_IDLE) || r_emv;
    assign o_cfg_ready = 1'b1;
    assign is_fact = (r_mode == MODE_FACT);

    // clamp the configured order
    always_comb begin
        if (r_size == '0) begin
            n_ord = CW'(1);
        end else if (r_size > CFG_W'(CAP)) begin
            n_ord = CW'(CAP);
        end else begin
            n_ord = CW'(r_size);
        end
    end

    // describe the entry being computed
    always_comb begin
        t_tr  = r_i;
        t_tc  = r_i;
        t_js  = '0;
        t_end = r_i;
        t_div = 1'b0;
        case (r_mode)
            MODE_FACT: begin
                if (r_i < r_k) begin
                    t_tr  = r_sub ? r_k : r_i;
                    t_tc  = r_sub ? r_i : r_k;
                    t_div = r_sub;
                end else begin
                    t_tr  = r_k;
                    t_tc  = r_k;
                    t_end = r_k;
                end
            end
            MODE_BWD: begin
                t_js  = r_i + CW'(1);
                t_end = n_ord;
                t_div = 1'b1;
            end
            default: t_end = r_i;
        endcase
    end

    assign last_fact = (r_i == r_k) && ((r_k + CW'(1)) == n_ord);
    assign stat_now  = r_zero ? STAT_ZERO : (r_sat ? STAT_SAT : STAT_OK);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc_go && op == OP_FACT) begin
                    n_state = (n_ord == CW'(1)) ? ST_CHK_RD : ST_BASE_RD;
                end else if (acc_go && op == OP_SOLVE) begin
                    n_state = ST_BASE_RD;
                end
            end
            ST_BASE_RD:  n_state = ST_BASE_LAT;
            ST_BASE_LAT: n_state = (r_j < r_end) ? ST_TERM_RD : ST_DIFF;
            ST_TERM_RD:  n_state = ST_TERM_LAT;
            ST_TERM_LAT: n_state = ST_MUL;
            ST_MUL:      n_state = ST_ACC;
            ST_ACC:      n_state = ((r_j + CW'(1)) < r_end) ? ST_TERM_RD : ST_DIFF;
            ST_DIFF:     n_state = t_div ? ST_DEN_RD : ST_WRITE;
            ST_DEN_RD:   n_state = ST_DEN_LAT;
            ST_DEN_LAT:  n_state = ST_DIV_GO;
            ST_DIV_GO:   n_state = (r_den == '0) ? ST_WRITE : ST_DIV_WAIT;
            ST_DIV_WAIT: n_state = div_done ? ST_WRITE : ST_DIV_WAIT;
            ST_WRITE: begin
                case (r_mode)
                    MODE_FACT: n_state = last_fact ? ST_CHK_RD : ST_BASE_RD;
                    MODE_BWD:  n_state = (r_i == '0) ? ST_EMIT : ST_BASE_RD;
                    default:   n_state = ST_BASE_RD;
                endcase
            end
            ST_CHK_RD:   n_state = ST_CHK_TST;
            ST_CHK_TST:  n_state = ((r_k + CW'(1)) == n_ord) ? ST_IDLE : ST_CHK_RD;
            ST_EMIT:     n_state = ((r_k + CW'(1)) == n_ord) ? ST_IDLE : ST_EMIT;
            default:     n_state = ST_IDLE;
        endcase
    end

    // cell port drive
    always_comb begin
        cell_ctl = '{rd_a: 1'b0, rd_b: 1'b0, b_src: SRC_MAT, wr: 1'b0, wr_sel: SRC_MAT};
        a_row   = t_tr[RW-1:0];
        a_col   = t_tc[RW-1:0];
        b_row   = r_j[RW-1:0];
        b_col   = t_tc[RW-1:0];
        wr_row  = t_tr[RW-1:0];
        wr_col  = t_tc[RW-1:0];
        wr_data = r_val;
        div_go  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                wr_row  = RW'(i_row);
                wr_col  = RW'(i_col);
                wr_data = i_value;
                if (acc_go && op == OP_WR_MAT) begin
                    cell_ctl.wr = (32'(i_row) < MAX_ORDER) && (32'(i_col) < MAX_ORDER);
                end
                if (acc_go && op == OP_WR_RHS) begin
                    cell_ctl.wr     = 32'(i_row) < MAX_ORDER;
                    cell_ctl.wr_sel = SRC_B;
                end
            end
            ST_BASE_RD: begin
                cell_ctl.rd_a  = is_fact;
                cell_ctl.rd_b  = !is_fact;
                cell_ctl.b_src = (r_mode == MODE_FWD) ? SRC_B : SRC_X;
                b_row          = r_i[RW-1:0];
            end
            ST_TERM_RD: begin
                cell_ctl.rd_a  = 1'b1;
                cell_ctl.rd_b  = 1'b1;
                cell_ctl.b_src = is_fact ? SRC_MAT : SRC_X;
                a_col          = r_j[RW-1:0];
            end
            ST_DEN_RD: begin
                cell_ctl.rd_a = 1'b1;
                a_row         = t_tc[RW-1:0];
            end
            ST_DIV_GO: div_go = (r_den != '0);
            ST_WRITE: begin
                cell_ctl.wr     = 1'b1;
                cell_ctl.wr_sel = is_fact ? SRC_MAT : SRC_X;
            end
            ST_CHK_RD: begin
                cell_ctl.rd_a = 1'b1;
                a_row         = r_k[RW-1:0];
                a_col         = r_k[RW-1:0];
            end
            ST_EMIT: begin
                cell_ctl.rd_b  = 1'b1;
                cell_ctl.b_src = SRC_X;
                b_row          = r_k[RW-1:0];
            end
            default: div_go = 1'b0;
        endcase
    end

    // row cell chain
    assign a_ch[0] = '0;
    assign b_ch[0] = '0;
    for (genvar g = 0; g < MAX_ORDER; g++) begin : g_cell
        dlu_cell #(
            .MAX_ORDER (MAX_ORDER),
            .CELL_ID   (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (cell_ctl),
            .i_a_row   (a_row),
            .i_a_col   (a_col),
            .i_b_row   (b_row),
            .i_b_col   (b_col),
            .i_wr_row  (wr_row),
            .i_wr_col  (wr_col),
            .i_wr_data (wr_data),
            .i_a_chain (a_ch[g]),
            .i_b_chain (b_ch[g]),
            .o_a_chain (a_ch[g+1]),
            .o_b_chain (b_ch[g+1])
        );
    end
    assign rd_a = a_ch[MAX_ORDER];
    assign rd_b = b_ch[MAX_ORDER];

    dlu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (r_val),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_ovf   (div_ovf)
    );

    // rounded product and saturated difference
    assign prod_full = $signed(r_opa) * $signed(r_opb);
    assign prod_rnd  = (prod_full + 64'sd32768) >>> FRAC_W;
    assign diff = $signed({{(ACC_W+1-VAL_W){r_base[VAL_W-1]}}, r_base})
                - $signed({r_acc[ACC_W-1], r_acc});
    always_comb begin
        diff_ovf = 1'b0;
        diff_sat = diff[VAL_W-1:0];
        if (diff > $signed((ACC_W+1)'(64'h7FFF_FFFF))) begin
            diff_ovf = 1'b1;
            diff_sat = 32'h7FFF_FFFF;
        end else if (diff < -$signed((ACC_W+1)'(64'h8000_0000))) begin
            diff_ovf = 1'b1;
            diff_sat = 32'h8000_0000;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_size   <= SIZE_RESET;
            r_emv    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_size <= i_cfg_data;
            end
            r_emv    <= (r_state == ST_EMIT);
            r_strobe <= r_emv ||
                        ((r_state == ST_CHK_TST) && ((r_k + CW'(1)) == n_ord));
        end
    end

    // sequencer counters and datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_zero <= 1'b0;
                r_sat  <= 1'b0;
                r_k    <= (n_ord == CW'(1)) ? '0 : CW'(1);
                r_i    <= '0;
                r_sub  <= 1'b0;
                r_mode <= (op == OP_SOLVE) ? MODE_FWD : MODE_FACT;
            end
            ST_BASE_RD: begin
                r_j   <= t_js;
                r_end <= t_end;
                r_acc <= '0;
            end
            ST_BASE_LAT: r_base <= is_fact ? rd_a : rd_b;
            ST_TERM_LAT: begin
                r_opa <= rd_a;
                r_opb <= rd_b;
            end
            ST_MUL: r_prod <= prod_rnd[PROD_W-1:0];
            ST_ACC: begin
                r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                r_j   <= r_j + CW'(1);
            end
            ST_DIFF: begin
                r_val <= diff_sat;
                if (diff_ovf) r_sat <= 1'b1;
            end
            ST_DEN_LAT: r_den <= rd_a;
            ST_DIV_GO: begin
                if (r_den == '0) begin
                    r_val  <= '0;
                    r_zero <= 1'b1;
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    r_val <= div_quot;
                    if (div_ovf) r_sat <= 1'b1;
                end
            end
            ST_WRITE: begin
                case (r_mode)
                    MODE_FACT: begin
                        if (last_fact) begin
                            r_k <= '0;
                        end else if (r_i == r_k) begin
                            r_k <= r_k + CW'(1);
                            r_i <= '0;
                        end else if (!r_sub) begin
                            r_sub <= 1'b1;
                        end else begin
                            r_sub <= 1'b0;
                            r_i   <= r_i + CW'(1);
                        end
                    end
                    MODE_FWD: begin
                        if ((r_i + CW'(1)) == n_ord) begin
                            r_mode <= MODE_BWD;
                        end else begin
                            r_i <= r_i + CW'(1);
                        end
                    end
                    default: begin
                        if (r_i == '0) begin
                            r_k <= '0;
                        end else begin
                            r_i <= r_i - CW'(1);
                        end
                    end
                endcase
            end
            ST_CHK_TST: begin
                if (rd_a == '0) r_zero <= 1'b1;
                r_k <= r_k + CW'(1);
            end
            ST_EMIT: r_k <= r_k + CW'(1);
            default: r_k <= r_k;
        endcase
    end

    // result staging
    always_ff @(posedge i_clk) begin
        r_emi <= r_k;
        r_eml <= (r_k + CW'(1)) == n_ord;
        if (r_emv) begin
            r_index  <= 3'(r_emi);
            r_res    <= rd_b;
            r_last   <= r_eml;
            r_status <= stat_now;
        end else begin
            r_index  <= '0;
            r_res    <= '0;
            r_last   <= 1'b1;
            r_status <= (rd_a == '0) ? STAT_ZERO : stat_now;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_index        = r_index;
    assign o_result_value = r_res;
    assign o_last         = r_last;
    assign o_status       = r_status;

    // checks
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_go && (op == OP_FACT || op == OP_SOLVE)) |=> o_busy)
        else $error("command did not raise busy");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_go |-> (r_den != '0))
        else $error("divider started on zero divisor");
    a_no_store_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cell_ctl.wr && r_state != ST_IDLE) |-> (r_state == ST_WRITE))
        else $error("cell write outside write step");

endmodule
`default_nettype wire
